// ===== hw/rtl/gsfp_pkg.sv =====
package gsfp_pkg;

   // Byte offsets inside a sensor data frame.
   localparam logic [4:0] POS_SEQUENCE     = 5'd2;
   localparam logic [4:0] POS_SYSTEM_INFO  = 5'd7;
   localparam logic [4:0] POS_GESTURE_LO   = 5'd10;
   localparam logic [4:0] POS_GESTURE_MID  = 5'd11;
   localparam logic [4:0] POS_GESTURE_HI   = 5'd13;
   localparam logic [4:0] POS_TOUCH_LO     = 5'd14;
   localparam logic [4:0] POS_TOUCH_HI     = 5'd15;
   localparam logic [4:0] POS_TOUCH_COUNT  = 5'd16;
   localparam logic [4:0] POS_WHEEL        = 5'd18;
   localparam logic [4:0] POS_X_LO         = 5'd20;
   localparam logic [4:0] POS_X_HI         = 5'd21;
   localparam logic [4:0] POS_Y_LO         = 5'd22;
   localparam logic [4:0] POS_Y_HI         = 5'd23;
   localparam logic [4:0] POS_Z_LO         = 5'd24;
   localparam logic [4:0] POS_Z_HI         = 5'd25;
   localparam logic [4:0] POS_LAST         = 5'd31;
   localparam logic [4:0] POS_FIRST_DATA   = 5'd1;

   localparam logic [7:0]  SHORT_FRAME_MAX = 8'd1;
   localparam logic [15:0] POSITION_RESET  = 16'hFFFF;
   localparam logic [2:0]  GESTURE_MAX     = 3'd5;

   // One report, as it leaves the block.
   typedef struct packed {
      logic [7:0]  swipe_code;
      logic [5:0]  touch_code;
      logic [6:0]  tap_code;
      logic [7:0]  double_tap_code;
      logic [7:0]  touch_count;
      logic [5:0]  wheel_slot;
      logic        position_valid;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] pos_z;
      logic [2:0]  gesture_count;
   } report_type;

endpackage

// ===== hw/rtl/gesture_sensor_frame_parser.sv =====
// Gesture sensor frame parser. Feed the bytes of a sensor data frame in order, one item per
// byte, with frame_start high on the length byte that opens each frame; a start always
// abandons any frame in progress, and bytes that arrive with no frame open are taken and
// ignored. One report leaves on the rsp_ channel for each frame that reaches its last byte
// (length byte minus one data bytes, or the length byte itself when it is 0 or 1). A frame
// whose sequence byte repeats the last accepted sequence number is dropped and gives no
// report. Touch, touch count and the X/Y/Z positions are held from frame to frame (positions
// read 0xFFFF until first written); swipe, tap, double tap, wheel and the gesture count
// start from zero in every frame. The block takes one byte per clock cycle when not stalled:
// each byte is decoded by a single stage of logic into the frame state registers, and the
// report is loaded into an output register in the same cycle as the last byte, so it is
// offered in the cycle after that byte is accepted. The input stalls only while a report sits
// in the output register and the consumer is not taking it.
module gesture_sensor_frame_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_swipe_code,
   output logic [5:0]  rsp_touch_code,
   output logic [6:0]  rsp_tap_code,
   output logic [7:0]  rsp_double_tap_code,
   output logic [7:0]  rsp_touch_count,
   output logic [5:0]  rsp_wheel_slot,
   output logic        rsp_position_valid,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [15:0] rsp_pos_z,
   output logic [2:0]  rsp_gesture_count
);
   import gsfp_pkg::*;

   // Frame tracking state.
   logic [4:0]  byte_pos_ff, byte_pos_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic        frame_active_ff, frame_active_in;
   logic [7:0]  prev_seq_ff, prev_seq_in;
   logic        pos_flag_ff, pos_flag_in;
   logic        wheel_flag_ff, wheel_flag_in;

   // Only the low 16 bits of the gesture accumulator ever matter: byte 12 is skipped, so
   // bits 16 to 23 stay clear (the edge-swipe bit never sets), and bit 31 is tested
   // straight from the byte that would supply it.
   logic [15:0] field_acc_ff, field_acc_in;

   // Decoded values carried into the report.
   logic [7:0]  swipe_ff, swipe_in;
   logic [5:0]  touch_ff, touch_in;
   logic [6:0]  tap_ff, tap_in;
   logic [7:0]  dtap_ff, dtap_in;
   logic [7:0]  touch_count_ff, touch_count_in;
   logic [5:0]  wheel_ff, wheel_in;
   logic [15:0] pos_x_ff, pos_x_in;
   logic [15:0] pos_y_ff, pos_y_in;
   logic [15:0] pos_z_ff, pos_z_in;
   logic [2:0]  tally_ff, tally_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   report_type  rsp_ff, rsp_in;

   logic        accept;
   logic        emit;
   logic [15:0] acc_upper;
   logic        touch_hit, tap_hit, dtap_hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // The middle gesture byte and the high touch byte add into bits 15:8 of what the low byte left there.
   assign acc_upper = {field_acc_ff[15:8] + req_rx_byte, field_acc_ff[7:0]};
   assign touch_hit = (acc_upper[4:0] != '0);
   assign tap_hit   = (acc_upper[9:5] != '0);
   assign dtap_hit  = (acc_upper[14:10] != '0);

   always_comb begin
      byte_pos_in     = byte_pos_ff;
      bytes_left_in   = bytes_left_ff;
      frame_active_in = frame_active_ff;
      prev_seq_in     = prev_seq_ff;
      pos_flag_in     = pos_flag_ff;
      wheel_flag_in   = wheel_flag_ff;
      field_acc_in    = field_acc_ff;
      swipe_in        = swipe_ff;
      touch_in        = touch_ff;
      tap_in          = tap_ff;
      dtap_in         = dtap_ff;
      touch_count_in  = touch_count_ff;
      wheel_in        = wheel_ff;
      pos_x_in        = pos_x_ff;
      pos_y_in        = pos_y_ff;
      pos_z_in        = pos_z_ff;
      tally_in        = tally_ff;
      emit            = 1'b0;

      if (accept) begin
         if (req_frame_start) begin
            // A new frame clears the per-frame fields and keeps the held ones.
            byte_pos_in   = POS_FIRST_DATA;
            swipe_in      = '0;
            tap_in        = '0;
            dtap_in       = '0;
            wheel_in      = '0;
            tally_in      = '0;
            pos_flag_in   = 1'b0;
            wheel_flag_in = 1'b0;
            field_acc_in  = '0;
            if (req_rx_byte <= SHORT_FRAME_MAX) begin
               frame_active_in = 1'b0;
               emit            = 1'b1;
            end else begin
               frame_active_in = 1'b1;
               bytes_left_in   = req_rx_byte - 8'd1;
            end
         end else if (frame_active_ff) begin
            if (byte_pos_ff != POS_LAST) begin
               byte_pos_in = byte_pos_ff + 5'd1;
            end
            bytes_left_in = bytes_left_ff - 8'd1;
            if (byte_pos_ff == POS_SEQUENCE && req_rx_byte == prev_seq_ff) begin
               // Repeated sequence number: drop the rest of the frame quietly.
               frame_active_in = 1'b0;
            end else begin
               unique case (byte_pos_ff)
                  POS_SEQUENCE: begin
                     prev_seq_in = req_rx_byte;
                  end
                  POS_SYSTEM_INFO: begin
                     pos_flag_in   = req_rx_byte[0];
                     wheel_flag_in = req_rx_byte[1];
                  end
                  POS_GESTURE_LO: begin
                     field_acc_in = {8'd0, req_rx_byte};
                  end
                  POS_GESTURE_MID: begin
                     field_acc_in = acc_upper;
                  end
                  POS_GESTURE_HI: begin
                     // A set top bit marks the gesture word as not to be used.
                     if (!req_rx_byte[7] &&
                         (field_acc_ff[7:2] != '0 || field_acc_ff[14:13] != '0)) begin
                        swipe_in = {1'b1, field_acc_ff[8], field_acc_ff[7:2]};
                        tally_in = tally_ff + 3'd1;
                     end
                     field_acc_in = '0;
                  end
                  POS_TOUCH_LO: begin
                     field_acc_in = {8'd0, req_rx_byte};
                  end
                  POS_TOUCH_HI: begin
                     field_acc_in = acc_upper;
                     touch_in = touch_hit ? {1'b1, acc_upper[4:0]} : 6'd0;
                     if (tap_hit) begin
                        tap_in = {2'b10, acc_upper[9:5]};
                     end
                     if (dtap_hit) begin
                        dtap_in = {3'b100, acc_upper[14:10]};
                     end
                     tally_in = tally_ff + {2'd0, touch_hit} + {2'd0, tap_hit}
                                + {2'd0, dtap_hit};
                  end
                  POS_TOUCH_COUNT: begin
                     touch_count_in = req_rx_byte;
                     field_acc_in   = '0;
                  end
                  POS_WHEEL: begin
                     if (wheel_flag_ff) begin
                        wheel_in = {1'b0, req_rx_byte[4:0]} + 6'd1;
                        tally_in = tally_ff + 3'd1;
                     end
                  end
                  POS_X_LO: begin
                     if (pos_flag_ff) pos_x_in = {8'd0, req_rx_byte};
                  end
                  POS_X_HI: begin
                     if (pos_flag_ff) pos_x_in = {pos_x_ff[15:8] + req_rx_byte, pos_x_ff[7:0]};
                  end
                  POS_Y_LO: begin
                     if (pos_flag_ff) pos_y_in = {8'd0, req_rx_byte};
                  end
                  POS_Y_HI: begin
                     if (pos_flag_ff) pos_y_in = {pos_y_ff[15:8] + req_rx_byte, pos_y_ff[7:0]};
                  end
                  POS_Z_LO: begin
                     if (pos_flag_ff) pos_z_in = {8'd0, req_rx_byte};
                  end
                  POS_Z_HI: begin
                     if (pos_flag_ff) pos_z_in = {pos_z_ff[15:8] + req_rx_byte, pos_z_ff[7:0]};
                  end
                  default: begin
                  end
               endcase
               if (bytes_left_in == '0) begin
                  frame_active_in = 1'b0;
                  emit            = 1'b1;
               end
            end
         end
      end
   end

   // The report carries the state as it stands after the frame's last byte.
   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_valid_in           = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in           = 1'b1;
         rsp_in.swipe_code      = swipe_in;
         rsp_in.touch_code      = touch_in;
         rsp_in.tap_code        = tap_in;
         rsp_in.double_tap_code = dtap_in;
         rsp_in.touch_count     = touch_count_in;
         rsp_in.wheel_slot      = wheel_in;
         rsp_in.position_valid  = pos_flag_in;
         rsp_in.pos_x           = pos_x_in;
         rsp_in.pos_y           = pos_y_in;
         rsp_in.pos_z           = pos_z_in;
         rsp_in.gesture_count   = tally_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff     <= '0;
         bytes_left_ff   <= '0;
         frame_active_ff <= 1'b0;
         prev_seq_ff     <= '0;
         pos_flag_ff     <= 1'b0;
         wheel_flag_ff   <= 1'b0;
         field_acc_ff    <= '0;
         swipe_ff        <= '0;
         touch_ff        <= '0;
         tap_ff          <= '0;
         dtap_ff         <= '0;
         touch_count_ff  <= '0;
         wheel_ff        <= '0;
         pos_x_ff        <= POSITION_RESET;
         pos_y_ff        <= POSITION_RESET;
         pos_z_ff        <= POSITION_RESET;
         tally_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         byte_pos_ff     <= byte_pos_in;
         bytes_left_ff   <= bytes_left_in;
         frame_active_ff <= frame_active_in;
         prev_seq_ff     <= prev_seq_in;
         pos_flag_ff     <= pos_flag_in;
         wheel_flag_ff   <= wheel_flag_in;
         field_acc_ff    <= field_acc_in;
         swipe_ff        <= swipe_in;
         touch_ff        <= touch_in;
         tap_ff          <= tap_in;
         dtap_ff         <= dtap_in;
         touch_count_ff  <= touch_count_in;
         wheel_ff        <= wheel_in;
         pos_x_ff        <= pos_x_in;
         pos_y_ff        <= pos_y_in;
         pos_z_ff        <= pos_z_in;
         tally_ff        <= tally_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_swipe_code      = rsp_ff.swipe_code;
   assign rsp_touch_code      = rsp_ff.touch_code;
   assign rsp_tap_code        = rsp_ff.tap_code;
   assign rsp_double_tap_code = rsp_ff.double_tap_code;
   assign rsp_touch_count     = rsp_ff.touch_count;
   assign rsp_wheel_slot      = rsp_ff.wheel_slot;
   assign rsp_position_valid  = rsp_ff.position_valid;
   assign rsp_pos_x           = rsp_ff.pos_x;
   assign rsp_pos_y           = rsp_ff.pos_y;
   assign rsp_pos_z           = rsp_ff.pos_z;
   assign rsp_gesture_count   = rsp_ff.gesture_count;

   // An open frame always has bytes still to come.
   a_active_has_bytes: assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> (bytes_left_ff != '0))
      else $error("open frame with no bytes left");

   // An open frame has moved past its length byte.
   a_active_position: assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> (byte_pos_ff != '0))
      else $error("open frame at byte position zero");

   // A length byte of 0 or 1 closes the frame and reports at once.
   a_short_frame: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_start && req_rx_byte <= SHORT_FRAME_MAX)
      |=> (rsp_valid_ff && !frame_active_ff))
      else $error("short frame did not report");

   // No frame decodes more than five gesture fields.
   a_tally_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.gesture_count <= GESTURE_MAX))
      else $error("gesture count out of range");

endmodule

// ===== tb/gesture_sensor_frame_parser_tb.sv =====
module gesture_sensor_frame_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gsfp_pkg::*;

   // Masks and flag bits used to decode the gesture and touch words of a frame.
   localparam logic [31:0] SWIPE_SIGN_BIT  = 32'h8000_0000;
   localparam logic [31:0] SWIPE_DIR_MASK  = 32'h0000_60FC;
   localparam logic [31:0] SWIPE_EDGE_BIT  = 32'h0001_0000;
   localparam logic [31:0] TOUCH_MASK      = 32'h0000_001F;
   localparam logic [31:0] TAP_MASK        = 32'h0000_03E0;
   localparam logic [31:0] DOUBLE_TAP_MASK = 32'h0000_7C00;
   localparam logic [7:0]  SWIPE_FLAG      = 8'b1000_0000;
   localparam logic [7:0]  EDGE_FLAG       = 8'b0100_0000;
   localparam logic [5:0]  TOUCH_FLAG      = 6'h20;
   localparam logic [6:0]  TAP_FLAG        = 7'h40;
   localparam logic [7:0]  DOUBLE_TAP_FLAG = 8'h80;

   localparam int IDLE_MAX       = 18;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = 8;

   // How the data bytes of a generated frame are filled.
   typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_ONES} fill_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_swipe_code;
   logic [5:0]  rsp_touch_code;
   logic [6:0]  rsp_tap_code;
   logic [7:0]  rsp_double_tap_code;
   logic [7:0]  rsp_touch_count;
   logic [5:0]  rsp_wheel_slot;
   logic        rsp_position_valid;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [15:0] rsp_pos_z;
   logic [2:0]  rsp_gesture_count;

   gesture_sensor_frame_parser uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_swipe_code      (rsp_swipe_code),
      .rsp_touch_code      (rsp_touch_code),
      .rsp_tap_code        (rsp_tap_code),
      .rsp_double_tap_code (rsp_double_tap_code),
      .rsp_touch_count     (rsp_touch_count),
      .rsp_wheel_slot      (rsp_wheel_slot),
      .rsp_position_valid  (rsp_position_valid),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_pos_z           (rsp_pos_z),
      .rsp_gesture_count   (rsp_gesture_count)
   );

   // A 20 ns clock. All stimulus moves on the falling edge, and every handshake and
   // output is sampled on the rising edge, so nothing hinges on event order.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Our own copy of the parser state. It advances once for every byte item that the
   // block accepts, in the same order, so it always mirrors what the block should hold.
   logic [4:0]  byte_position;
   logic [7:0]  bytes_left;
   bit          frame_active;
   logic [7:0]  previous_sequence;
   bit          position_flag;
   bit          wheel_flag;
   logic [31:0] field_acc;
   logic [7:0]  held_swipe;
   logic [5:0]  held_touch;
   logic [6:0]  held_tap;
   logic [7:0]  held_double_tap;
   logic [7:0]  held_touch_count;
   logic [5:0]  held_wheel;
   logic [15:0] held_position [3];
   logic [2:0]  gesture_tally;

   // Reports that the block owes us, oldest first.
   report_type  pending_reports [$];

   // The frame under construction; byte 0 is the length byte.
   logic [7:0]  frame_buf [$];

   // Pacing controls. The idle switches give stretches with and without gaps; the hold
   // counter is loaded by a test and counted down by the receiver process.
   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   int hold_left     = 0;
   int ready_wait    = 0;
   bit rsp_taken     = 1'b0;

   int error_count        = 0;
   int items_sent         = 0;
   int reports_checked    = 0;
   int frames_dropped     = 0;
   int input_stall_cycles = 0;

   function automatic int draw_gap(input bit enabled);
      return enabled ? $urandom_range(0, IDLE_MAX) : 0;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch(name, int'(got), int'(want));
   endtask

   function automatic report_type current_report();
      report_type r;
      r.swipe_code      = held_swipe;
      r.touch_code      = held_touch;
      r.tap_code        = held_tap;
      r.double_tap_code = held_double_tap;
      r.touch_count     = held_touch_count;
      r.wheel_slot      = held_wheel;
      r.position_valid  = position_flag;
      r.pos_x           = held_position[0];
      r.pos_y           = held_position[1];
      r.pos_z           = held_position[2];
      r.gesture_count   = gesture_tally;
      return r;
   endfunction

   task automatic reset_parser_state();
      byte_position     = '0;
      bytes_left        = '0;
      frame_active      = 1'b0;
      previous_sequence = '0;
      position_flag     = 1'b0;
      wheel_flag        = 1'b0;
      field_acc         = '0;
      held_swipe        = '0;
      held_touch        = '0;
      held_tap          = '0;
      held_double_tap   = '0;
      held_touch_count  = '0;
      held_wheel        = '0;
      for (int k = 0; k < 3; k++)
         held_position[k] = POSITION_RESET;
      gesture_tally     = '0;
   endtask

   // Decodes one data byte at its frame offset. Byte 12 falls to the default on purpose,
   // so the edge bit of the gesture word can never be set.
   task automatic decode_field(input logic [4:0] pos, input logic [7:0] d);
      logic [31:0] acc;
      int          k;
      acc = field_acc;
      case (pos)
         POS_SYSTEM_INFO: begin
            position_flag = d[0];
            wheel_flag    = d[1];
         end
         POS_GESTURE_LO: acc = {24'd0, d};
         POS_GESTURE_MID: acc = acc + {16'd0, d, 8'd0};
         POS_GESTURE_HI: begin
            acc = acc + {d, 24'd0};
            if ((acc & SWIPE_SIGN_BIT) == 0 && (acc & SWIPE_DIR_MASK) != 0) begin
               held_swipe = held_swipe | acc[9:2] | SWIPE_FLAG;
               if ((acc & SWIPE_EDGE_BIT) != 0)
                  held_swipe = held_swipe | EDGE_FLAG;
               gesture_tally++;
            end
            acc = '0;
         end
         POS_TOUCH_LO: acc = {24'd0, d};
         POS_TOUCH_HI: begin
            acc = acc + {16'd0, d, 8'd0};
            if ((acc & TOUCH_MASK) != 0) begin
               held_touch = TOUCH_FLAG | {1'b0, acc[4:0]};
               gesture_tally++;
            end else begin
               held_touch = '0;
            end
            if ((acc & TAP_MASK) != 0) begin
               held_tap = TAP_FLAG | {2'b00, acc[9:5]};
               gesture_tally++;
            end
            if ((acc & DOUBLE_TAP_MASK) != 0) begin
               held_double_tap = DOUBLE_TAP_FLAG | {3'b000, acc[14:10]};
               gesture_tally++;
            end
         end
         POS_TOUCH_COUNT: begin
            held_touch_count = d;
            acc = '0;
         end
         POS_WHEEL: begin
            if (wheel_flag) begin
               held_wheel = {1'b0, d[4:0]} + 6'd1;
               gesture_tally++;
            end
         end
         POS_X_LO, POS_Y_LO, POS_Z_LO: begin
            k = int'((pos - POS_X_LO) >> 1);
            if (position_flag)
               held_position[k] = {8'd0, d};
         end
         POS_X_HI, POS_Y_HI, POS_Z_HI: begin
            k = int'((pos - POS_X_HI) >> 1);
            if (position_flag)
               held_position[k] = held_position[k] + {d, 8'd0};
         end
         default: ;
      endcase
      field_acc = acc;
   endtask

   // Advances the mirrored state by one accepted byte and queues a report when the byte
   // closes a frame.
   task automatic predict_byte(input logic [7:0] data, input bit start);
      logic [4:0] pos;
      bit         closes;
      closes = 1'b0;
      if (start) begin
         // A start abandons whatever frame was open. Touch, touch count and the
         // positions carry over; every other report field begins from zero.
         frame_active    = 1'b1;
         byte_position   = POS_FIRST_DATA;
         held_swipe      = '0;
         held_tap        = '0;
         held_double_tap = '0;
         held_wheel      = '0;
         gesture_tally   = '0;
         position_flag   = 1'b0;
         wheel_flag      = 1'b0;
         field_acc       = '0;
         if (data <= SHORT_FRAME_MAX) begin
            frame_active = 1'b0;
            closes       = 1'b1;
         end else begin
            bytes_left = data - 8'd1;
         end
      end else if (frame_active) begin
         pos = byte_position;
         if (byte_position < POS_LAST)
            byte_position++;
         bytes_left = bytes_left - 8'd1;
         if (pos == POS_SEQUENCE && data == previous_sequence) begin
            // Same sequence number as the last frame: drop it silently.
            frame_active = 1'b0;
            frames_dropped++;
         end else begin
            if (pos == POS_SEQUENCE)
               previous_sequence = data;
            else
               decode_field(pos, data);
            if (bytes_left == 0) begin
               frame_active = 1'b0;
               closes       = 1'b1;
            end
         end
      end
      if (closes)
         pending_reports.push_back(current_report());
   endtask

   // Offers one byte item after a random gap and holds it until the block takes it.
   // Entered and left on a falling edge.
   task automatic send_byte(input logic [7:0] data, input bit start);
      int gap;
      gap = draw_gap(sender_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= data;
      req_frame_start <= start;
      do
         @(posedge clock);
      while (!req_ready);
      predict_byte(data, start);
      items_sent++;
      @(negedge clock);
   endtask

   // Builds a frame of the given length byte. The sequence byte is either fresh or a
   // copy of the last accepted one, which makes the block drop the frame.
   task automatic build_frame(input int length, input bit fresh, input fill_mode_type fill);
      int         n;
      logic [7:0] b;
      frame_buf.delete();
      n = (length <= 1) ? 1 : length;
      for (int i = 0; i < n; i++) begin
         case (fill)
            FILL_ZEROS: b = 8'h00;
            FILL_ONES:  b = 8'hFF;
            default:    b = 8'($urandom);
         endcase
         if (i == 0) begin
            b = length[7:0];
         end else if (i == POS_SEQUENCE) begin
            if (fresh) begin
               do
                  b = 8'($urandom_range(0, 255));
               while (b == previous_sequence);
            end else begin
               b = previous_sequence;
            end
         end else if (fill == FILL_RANDOM) begin
            // Lean the random content toward frames that actually decode something,
            // while keeping the empty cases in reach.
            if (i == POS_SYSTEM_INFO && $urandom_range(0, 3) != 0)
               b = b | 8'h03;
            if ((i == POS_GESTURE_LO || i == POS_GESTURE_MID) && $urandom_range(0, 5) == 0)
               b = 8'h00;
            if (i == POS_GESTURE_HI && $urandom_range(0, 2) != 0)
               b[7] = 1'b0;
            if ((i == POS_TOUCH_LO || i == POS_TOUCH_HI) && $urandom_range(0, 4) == 0)
               b = 8'h00;
         end
         frame_buf.push_back(b);
      end
   endtask

   task automatic send_frame(input int count);
      for (int i = 0; i < count && i < frame_buf.size(); i++)
         send_byte(frame_buf[i], i == 0);
   endtask

   // Stops offering items until every report the block owes has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_reports.size() != 0);
   endtask

   // Length bytes of 0 and 1 close the frame on the length byte itself; a length of 2
   // closes it on byte 1, before the sequence number is ever seen.
   task automatic test_short_frames();
      build_frame(0, 1'b1, FILL_RANDOM);
      send_frame(frame_buf.size());
      build_frame(1, 1'b1, FILL_RANDOM);
      send_frame(frame_buf.size());
      build_frame(2, 1'b1, FILL_ONES);
      send_frame(frame_buf.size());
   endtask

   // Bytes with no frame open must be swallowed without any report.
   task automatic test_stray_bytes();
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // The first frame repeats the sequence number left over from reset, so it is dropped
   // and its later bytes are ignored. A fresh frame follows, then one repeating it.
   task automatic test_repeated_sequence();
      build_frame(4, 1'b0, FILL_ONES);
      send_frame(frame_buf.size());
      build_frame(3, 1'b1, FILL_RANDOM);
      send_frame(frame_buf.size());
      build_frame(5, 1'b0, FILL_RANDOM);
      send_frame(frame_buf.size());
   endtask

   // A new length byte in the middle of a frame throws the open frame away.
   task automatic test_abandoned_frame();
      build_frame(24, 1'b1, FILL_ONES);
      send_frame(8);
      build_frame(1, 1'b1, FILL_RANDOM);
      send_frame(frame_buf.size());
   endtask

   // The receiver stops taking reports for a long stretch while the sender keeps
   // offering short frames, so the output register fills and the input stalls.
   task automatic test_backpressure();
      bit keep_receiver_idle;
      keep_receiver_idle = receiver_idle;
      receiver_idle = 1'b0;
      hold_left = LONG_HOLD;
      for (int f = 0; f < 6; f++) begin
         build_frame($urandom_range(0, 3), 1'b1, FILL_RANDOM);
         send_frame(frame_buf.size());
      end
      wait_drained();
      receiver_idle = keep_receiver_idle;
   endtask

   // The sender goes quiet until every report is out, then carries on.
   task automatic test_drain_pause();
      build_frame(26, 1'b1, FILL_ZEROS);
      send_frame(frame_buf.size());
      wait_drained();
      build_frame(26, 1'b1, FILL_RANDOM);
      send_frame(frame_buf.size());
      wait_drained();
   endtask

   // Mostly complete frames, mainly with random content; the rest are short, dropped, cut off,
   // stray, or longer than the decoded region, with an occasional pause to drain the reports.
   task automatic test_random_frames();
      int            pick;
      int            len;
      fill_mode_type fill;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            sender_idle   = 1'($urandom_range(0, 1));
            receiver_idle = 1'($urandom_range(0, 1));
         end
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0:       fill = FILL_ZEROS;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         if (pick < 68) begin
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(26, 30)
                                              : $urandom_range(20, 25);
            build_frame(len, 1'b1, fill);
            send_frame(frame_buf.size());
         end else if (pick < 78) begin
            build_frame($urandom_range(0, 19), 1'b1, fill);
            send_frame(frame_buf.size());
         end else if (pick < 83) begin
            build_frame($urandom_range(3, 30), 1'b0, fill);
            send_frame(frame_buf.size());
         end else if (pick < 89) begin
            // A length byte from 3 to 255, cut off early by the next frame's start.
            len = $urandom_range(3, 255);
            build_frame(len, 1'b1, fill);
            send_frame($urandom_range(1, (len - 1 < 20) ? len - 1 : 20));
         end else if (pick < 94) begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom), 1'b0);
         end else if (pick < 97) begin
            build_frame($urandom_range(31, 80), 1'b1, fill);
            send_frame(frame_buf.size());
         end else if (pick < 98) begin
            build_frame($urandom_range(200, 255), 1'b1, fill);
            send_frame(frame_buf.size());
         end else begin
            wait_drained();
         end
      end
   endtask

   // Receiver: after each report taken it draws a wait, and a long hold loaded by a
   // test is counted down here one cycle at a time.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         if (rsp_taken) begin
            ready_wait = draw_gap(receiver_idle);
            rsp_taken  = 1'b0;
         end
         if (ready_wait > 0) begin
            rsp_ready <= 1'b0;
            ready_wait--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Checker: every report taken is compared field by field with the oldest one owed.
   always @(posedge clock) begin : report_checker
      report_type want;
      if (!reset) begin
         if (req_valid && !req_ready)
            input_stall_cycles++;
         if (rsp_valid && rsp_ready) begin
            rsp_taken = 1'b1;
            if (pending_reports.size() == 0) begin
               report_mismatch("report with none owed", 0, 0);
            end else begin
               want = pending_reports.pop_front();
               check_field("swipe_code", 16'(rsp_swipe_code), 16'(want.swipe_code));
               check_field("touch_code", 16'(rsp_touch_code), 16'(want.touch_code));
               check_field("tap_code", 16'(rsp_tap_code), 16'(want.tap_code));
               check_field("double_tap_code", 16'(rsp_double_tap_code),
                           16'(want.double_tap_code));
               check_field("touch_count", 16'(rsp_touch_count), 16'(want.touch_count));
               check_field("wheel_slot", 16'(rsp_wheel_slot), 16'(want.wheel_slot));
               check_field("position_valid", 16'(rsp_position_valid),
                           16'(want.position_valid));
               check_field("pos_x", rsp_pos_x, want.pos_x);
               check_field("pos_y", rsp_pos_y, want.pos_y);
               check_field("pos_z", rsp_pos_z, want.pos_z);
               check_field("gesture_count", 16'(rsp_gesture_count), 16'(want.gesture_count));
               reports_checked++;
            end
         end
      end
   end

   // Main sequence: one reset, the directed cases, the pressure cases, then the random
   // mix. At the end the sender goes idle, every owed report must arrive, and a few more
   // cycles pass so that a stray extra report would still be caught.
   initial begin
      reset_parser_state();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_short_frames();
      test_stray_bytes();
      test_repeated_sequence();
      test_abandoned_frame();
      test_backpressure();
      test_drain_pause();
      test_random_frames();

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Sent %0d byte items; checked %0d reports; %0d frames dropped on a repeated",
               items_sent, reports_checked, frames_dropped);
      $display("sequence number; input held off for %0d cycles by a full output.",
               input_stall_cycles);
      if (error_count == 0)
         $display("PASS gesture_sensor_frame_parser");
      else
         $display("FAIL gesture_sensor_frame_parser");
      $finish;
   end

   // Watchdog: far longer than the slowest correct run needs.
   initial begin
      #10_000_000;
      $display("FAIL gesture_sensor_frame_parser");
      $finish;
   end

endmodule

// ===== gesture_sensor_frame_parser.f =====
hw/rtl/gsfp_pkg.sv
hw/rtl/gesture_sensor_frame_parser.sv
tb/gesture_sensor_frame_parser_tb.sv
